### rtl/path_check_and_hash_core_defines.svh
// ----------------------------------------------------------------------------
// path_check_and_hash_core_defines
// Assertion macros for the path check and hash core.
// ----------------------------------------------------------------------------
`ifndef PATH_CHECK_AND_HASH_CORE_DEFINES_SVH
`define PATH_CHECK_AND_HASH_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PCH_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PCH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pch_pkg.sv
// ----------------------------------------------------------------------------
// pch_pkg
// Constants, types and the FNV-1a step shared by the path check and hash RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pch_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    localparam logic [1:0] SEG_EMPTY = 2'd0;
    localparam logic [1:0] SEG_ONE   = 2'd1;
    localparam logic [1:0] SEG_TWO   = 2'd2;
    localparam logic [1:0] SEG_MANY  = 2'd3;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] hash;
    } pch_result_t;

    // (h ^ c) * 0x01000193 mod 2^32, as shifts and adds
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] c);
        logic [31:0] x;
        begin
            x = h ^ {24'd0, c};
            return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
        end
    endfunction

endpackage

### rtl/pch_path_if.sv
// ----------------------------------------------------------------------------
// pch_path_if
// Byte request channel: one path byte per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pch_path_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

### rtl/pch_result_if.sv
// ----------------------------------------------------------------------------
// pch_result_if
// Result request channel: verdict and hash for one terminated path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pch_result_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [31:0] hash;

    modport source (output valid, output valid_res, output hash, input ready);
    modport sink   (input valid, input valid_res, input hash, output ready);
endinterface

### rtl/pch_path_track.sv
// ----------------------------------------------------------------------------
// pch_path_track
// Per-path state: running FNV-1a hash, segment length, dot marks, error flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pch_path_track
    import pch_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  ch,
    output pch_result_t res
);

    logic [31:0] hash_acc_reg, hash_acc_next;
    logic [1:0]  seg_len_reg, seg_len_next;
    logic        first_dot_reg, first_dot_next;
    logic        second_dot_reg, second_dot_next;
    logic        bad_reg, bad_next;
    logic        dotdot;
    logic        is_dot;

    assign dotdot = (seg_len_reg == SEG_TWO) && first_dot_reg && second_dot_reg;
    assign is_dot = (ch == CH_DOT);

    assign res.valid_res = !bad_reg && (seg_len_reg != SEG_EMPTY) && !dotdot;
    assign res.hash      = hash_acc_reg;

    always_comb
    begin
        hash_acc_next   = hash_acc_reg;
        seg_len_next    = seg_len_reg;
        first_dot_next  = first_dot_reg;
        second_dot_next = second_dot_reg;
        bad_next        = bad_reg;
        if (step)
        begin
            if (ch == CH_NUL)
            begin
                hash_acc_next   = FNV_BASIS;
                seg_len_next    = SEG_EMPTY;
                first_dot_next  = 1'b0;
                second_dot_next = 1'b0;
                bad_next        = 1'b0;
            end
            else
            begin
                hash_acc_next = fnv_step(hash_acc_reg, ch);
                if (ch == CH_SLASH)
                begin
                    bad_next        = bad_reg || (seg_len_reg == SEG_EMPTY) || dotdot;
                    seg_len_next    = SEG_EMPTY;
                    first_dot_next  = 1'b0;
                    second_dot_next = 1'b0;
                end
                else
                begin
                    bad_next = bad_reg || (ch == CH_BSLASH) || (ch == CH_COLON);
                    if (seg_len_reg == SEG_EMPTY)
                    begin
                        first_dot_next = is_dot;
                    end
                    if (seg_len_reg == SEG_ONE)
                    begin
                        second_dot_next = is_dot;
                    end
                    if (seg_len_reg != SEG_MANY)
                    begin
                        seg_len_next = seg_len_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_acc_reg   <= FNV_BASIS;
            seg_len_reg    <= SEG_EMPTY;
            first_dot_reg  <= 1'b0;
            second_dot_reg <= 1'b0;
            bad_reg        <= 1'b0;
        end
        else
        begin
            hash_acc_reg   <= hash_acc_next;
            seg_len_reg    <= seg_len_next;
            first_dot_reg  <= first_dot_next;
            second_dot_reg <= second_dot_next;
            bad_reg        <= bad_next;
        end
    end

endmodule

### rtl/path_check_and_hash_core.sv
// ----------------------------------------------------------------------------
// path_check_and_hash_core
// Relative path checker with FNV-1a 32-bit hash, one byte per request.
// ----------------------------------------------------------------------------
// Takes one path byte per cycle, back to back, except while the input stalls.
// A zero byte ends the path; once it has passed the input register and been
// pushed into the output buffer, the result carries the verdict (no backslash,
// colon, empty or ".." segment before a slash, nonempty final segment that is
// not "..") and the hash of every byte before it. Each byte passes an input
// register and a single shift-add update of the hash register. Results go to
// a two-entry output buffer, so bytes keep flowing while a result waits; input
// stalls only when both entries are full and a terminator is waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "path_check_and_hash_core_defines.svh"

module path_check_and_hash_core
    import pch_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    pch_path_if.sink     path,
    pch_result_if.source result
);

    logic        in_vld_reg, in_vld_next;
    logic [7:0]  in_ch_reg;
    logic        step;
    logic        push;
    logic        pop;
    pch_result_t new_res;

    logic        head_vld_reg, head_vld_next;
    logic        tail_vld_reg, tail_vld_next;
    pch_result_t head_reg, head_next;
    pch_result_t tail_reg, tail_next;

    assign step       = in_vld_reg && ((in_ch_reg != CH_NUL) || !tail_vld_reg);
    assign push       = step && (in_ch_reg == CH_NUL);
    assign pop        = head_vld_reg && result.ready;
    assign path.ready = !in_vld_reg || step;

    assign in_vld_next = path.valid || (in_vld_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (path.valid && path.ready)
        begin
            in_ch_reg <= path.ch;
        end
    end

    pch_path_track u_track (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .ch    (in_ch_reg),
        .res   (new_res)
    );

    always_comb
    begin
        head_vld_next = head_vld_reg;
        tail_vld_next = tail_vld_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        if (pop)
        begin
            head_next     = tail_reg;
            head_vld_next = tail_vld_reg;
            tail_vld_next = 1'b0;
            if (push)
            begin
                if (tail_vld_reg)
                begin
                    tail_next     = new_res;
                    tail_vld_next = 1'b1;
                end
                else
                begin
                    head_next     = new_res;
                    head_vld_next = 1'b1;
                end
            end
        end
        else if (push)
        begin
            if (!head_vld_reg)
            begin
                head_next     = new_res;
                head_vld_next = 1'b1;
            end
            else
            begin
                tail_next     = new_res;
                tail_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= 1'b0;
            tail_vld_reg <= 1'b0;
        end
        else
        begin
            head_vld_reg <= head_vld_next;
            tail_vld_reg <= tail_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign result.valid     = head_vld_reg;
    assign result.valid_res = head_reg.valid_res;
    assign result.hash      = head_reg.hash;

    `PCH_ASSERT_IMPL(a_tail_needs_head, tail_vld_reg, head_vld_reg, "tail valid without head")
    `PCH_ASSERT_NEXT(a_push_lands, push, head_vld_reg, "pushed result not visible")
    `PCH_ASSERT_NEXT(a_fill_tail, head_vld_reg && !pop && push, tail_vld_reg, "result lost")

endmodule

### verif/path_check_and_hash_core_tb.sv
// ----------------------------------------------------------------------------
// path_check_and_hash_core_tb
// Self-checking bench for the relative path checker and FNV-1a hasher.
// ----------------------------------------------------------------------------
// Paths go in one byte per request and end with a zero byte. Each accepted
// byte is folded into a local model of the checker. The model works out the
// verdict and the hash that each terminator should produce. A monitor
// compares every result request with the oldest pending prediction, field by
// field. Directed paths cover the slash, dot and forbidden-character rules
// and the byte extremes. Random paths, mostly well formed with occasional
// rule breaks plus some raw noise, then run under three idle mixes. A long
// hold on the result side fills the block and stalls its input. A watchdog
// ends the run if no request moves for too long.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module path_check_and_hash_core_tb;
    import pch_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_BYTES  = 450;

    logic clk;
    logic rst_n;

    pch_path_if   path_ch();
    pch_result_if result_ch();

    path_check_and_hash_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .path   (path_ch),
        .result (result_ch)
    );

    // model state
    logic [31:0] model_hash;
    logic [1:0]  seg_len;
    logic        seg_first_dot;
    logic        seg_second_dot;
    logic        path_bad;

    pch_result_t pending_verdicts[$];

    int src_idle_pct;
    int rcv_idle_pct;
    int hold_request;
    int bytes_sent;
    int paths_sent;
    int results_seen;
    int valid_seen;
    int input_stalls;
    int mismatches;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function void clear_path_state();
        model_hash     = FNV_BASIS;
        seg_len        = SEG_EMPTY;
        seg_first_dot  = 1'b0;
        seg_second_dot = 1'b0;
        path_bad       = 1'b0;
    endfunction

    function void fold_path_byte(input logic [7:0] c);
        pch_result_t verdict;
        logic        seg_dotdot;
        seg_dotdot = (seg_len == SEG_TWO) && seg_first_dot && seg_second_dot;
        if (c == CH_NUL)
        begin
            verdict.valid_res = !path_bad && (seg_len != SEG_EMPTY) && !seg_dotdot;
            verdict.hash      = model_hash;
            pending_verdicts.push_back(verdict);
            clear_path_state();
        end
        else
        begin
            model_hash = (model_hash ^ {24'd0, c}) * FNV_PRIME;
            if (c == CH_SLASH)
            begin
                if (seg_len == SEG_EMPTY || seg_dotdot)
                    path_bad = 1'b1;
                seg_len        = SEG_EMPTY;
                seg_first_dot  = 1'b0;
                seg_second_dot = 1'b0;
            end
            else
            begin
                if (c == CH_BSLASH || c == CH_COLON)
                    path_bad = 1'b1;
                if (seg_len == SEG_EMPTY)
                    seg_first_dot = (c == CH_DOT);
                else if (seg_len == SEG_ONE)
                    seg_second_dot = (c == CH_DOT);
                if (seg_len != SEG_MANY)
                    seg_len = seg_len + 2'd1;
            end
        end
    endfunction

    function void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    initial clear_path_state();

    always @(posedge clk)
    begin
        pch_result_t want;
        if (rst_n)
        begin
            if (path_ch.valid && path_ch.ready)
                fold_path_byte(path_ch.ch);
            if (path_ch.valid && !path_ch.ready)
                input_stalls++;
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (pending_verdicts.size() == 0)
                    note_mismatch("result request with no path pending");
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (result_ch.valid_res !== want.valid_res)
                        note_mismatch($sformatf("valid_res expected %0b got %0b",
                                                want.valid_res, result_ch.valid_res));
                    if (result_ch.hash !== want.hash)
                        note_mismatch($sformatf("hash expected %08h got %08h",
                                                want.hash, result_ch.hash));
                    if (want.valid_res)
                        valid_seen++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((path_ch.valid && path_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no request moved in %0d cycles, %0d results pending",
                     STALL_LIMIT, pending_verdicts.size());
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random ready, or a counted hold when one is requested
    initial
    begin
        int hold_left;
        hold_left       = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            path_ch.valid <= 1'b0;
            @(negedge clk);
        end
        path_ch.valid <= 1'b1;
        path_ch.ch    <= b;
        do
            @(posedge clk);
        while (!path_ch.ready);
        bytes_sent++;
        if (b == CH_NUL)
            paths_sent++;
    endtask

    task automatic send_path_str(input string s);
        foreach (s[i])
            send_byte(s[i]);
        send_byte(CH_NUL);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        path_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_name_byte();
        logic [7:0] b;
        if ($urandom_range(7) == 0)
            b = CH_DOT;
        else
        begin
            do
                b = 8'($urandom_range(1, 255));
            while (b == CH_SLASH || b == CH_BSLASH || b == CH_COLON);
        end
        return b;
    endfunction

    task automatic send_random_path();
        int nseg;
        int nlen;
        int kind;
        kind = $urandom_range(99);
        if (kind < 10)
        begin
            // raw noise, any nonzero byte
            nlen = $urandom_range(0, 8);
            repeat (nlen)
                send_byte(8'($urandom_range(1, 255)));
        end
        else
        begin
            nseg = $urandom_range(1, 4);
            if ($urandom_range(19) == 0)
                send_byte(CH_SLASH);
            for (int s = 0; s < nseg; s++)
            begin
                if (s > 0)
                begin
                    send_byte(CH_SLASH);
                    if ($urandom_range(29) == 0)
                        send_byte(CH_SLASH);
                end
                case ($urandom_range(9))
                    0: send_byte(CH_DOT);
                    1: begin send_byte(CH_DOT); send_byte(CH_DOT); end
                    2: repeat (3) send_byte(CH_DOT);
                    default:
                    begin
                        nlen = $urandom_range(1, 5);
                        repeat (nlen)
                        begin
                            if ($urandom_range(39) == 0)
                                send_byte($urandom_range(1) ? CH_BSLASH : CH_COLON);
                            else
                                send_byte(pick_name_byte());
                        end
                    end
                endcase
            end
            if ($urandom_range(19) == 0)
                send_byte(CH_SLASH);
        end
        send_byte(CH_NUL);
    endtask

    task automatic test_empty_and_extremes();
        send_path_str("");
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(CH_NUL);
        wait_drain();
    endtask

    task automatic test_slash_rules();
        send_path_str("/");
        send_path_str("a//");
        wait_drain();
    endtask

    task automatic test_dot_segments();
        send_path_str("..");
        send_path_str("../.");
        send_path_str("...");
        wait_drain();
    endtask

    task automatic test_forbidden_chars();
        send_path_str(":\\");
        wait_drain();
    endtask

    task automatic test_random_paths(input int src_pct, input int rcv_pct, input int nbytes);
        int target;
        src_idle_pct = src_pct;
        rcv_idle_pct = rcv_pct;
        target       = bytes_sent + nbytes;
        while (bytes_sent < target)
            send_random_path();
        wait_drain();
    endtask

    task automatic test_input_stall();
        src_idle_pct = 0;
        rcv_idle_pct = 0;
        @(posedge clk);
        hold_request = HOLD_CYCLES;
        repeat (30)
            send_path_str("ok");
        wait_drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        path_ch.valid = 1'b0;
        path_ch.ch    = 8'h00;
        src_idle_pct  = 31;
        rcv_idle_pct  = 80;
        hold_request  = 0;
        bytes_sent    = 0;
        paths_sent    = 0;
        results_seen  = 0;
        valid_seen    = 0;
        input_stalls  = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_and_extremes();
        test_slash_rules();
        test_dot_segments();
        test_forbidden_chars();
        test_random_paths(31, 80, PHASE_BYTES);
        test_random_paths(80, 31, PHASE_BYTES);
        test_random_paths(0, 0, PHASE_BYTES);
        test_input_stall();

        wait_drain();
        repeat (10) @(posedge clk);

        $display("Sent %0d paths (%0d bytes) over three idle mixes and a %0d-cycle hold",
                 paths_sent, bytes_sent, HOLD_CYCLES);
        $display("Checked %0d results, %0d valid, %0d input stall cycles, %0d mismatches",
                 results_seen, valid_seen, input_stalls, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
